// ===== rtl/lsp_pkg.sv =====
// lsp_pkg.sv: shared types, constants and control structs for the lot sizing block
`timescale 1ns / 1ps
package lsp_pkg;

  localparam int VAL_W     = 32;
  localparam int FRAC_BITS = 16;
  localparam int COST_W    = 48;
  localparam int IDX_W     = 6;
  localparam int OP_W      = 64;
  localparam int PROD_W    = 2 * OP_W;
  localparam int DVD_W     = VAL_W + FRAC_BITS - 1;

  localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
  localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

  typedef struct packed {
    logic             first_period;
    logic [VAL_W-1:0] demand_intercept;
    logic [VAL_W-1:0] price_slope;
    logic [VAL_W-1:0] unit_cost;
    logic [VAL_W-1:0] setup_cost;
    logic [VAL_W-1:0] holding_cost;
  } in_item_t;

  typedef struct packed {
    logic signed [COST_W-1:0] best_cost;
    logic [IDX_W-1:0]         best_start;
    logic                     no_production;
    logic [IDX_W-1:0]         period_index;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic rd_bt;
    logic setup;
    logic rd;
    logic calc_u;
    logic mul1;
    logic dem;
    logic mul2;
    logic upd;
    logic fin;
    logic emit;
  } lsp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ratio_ok;
    logic mul_done;
    logic last_s;
    logic out_free;
  } lsp_sts_t;

  // saturating add in the cost range
  function automatic logic signed [COST_W-1:0] sat_add(
      input logic signed [COST_W-1:0] a, input logic signed [COST_W-1:0] b);
    logic signed [COST_W:0] s;
    s = {a[COST_W-1], a} + {b[COST_W-1], b};
    if (s[COST_W] != s[COST_W-1]) begin
      return s[COST_W] ? COST_MIN : COST_MAX;
    end
    return s[COST_W-1:0];
  endfunction

endpackage

// ===== rtl/lsp_mul.sv =====
// lsp_mul.sv: multi-cycle unsigned 64 x 64 multiplier built on one 32 x 32 product
`timescale 1ns / 1ps
module lsp_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lsp_pkg::OP_W-1:0]   a,
  input  logic [lsp_pkg::OP_W-1:0]   b,
  output logic                       done,
  output logic [lsp_pkg::PROD_W-1:0] prod
);
  import lsp_pkg::*;

  localparam int HW = OP_W / 2;

  logic              run_r;
  logic              done_r;
  logic              pp_v_r;
  logic [2:0]        cnt_r;
  logic [OP_W-1:0]   a_r, b_r;
  logic [OP_W-1:0]   pp_r;
  logic [1:0]        sh_r;
  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] pp_sh;
  logic [HW-1:0]     a_part, b_part;

  // partial operand selection by step
  assign a_part = cnt_r[0] ? a_r[OP_W-1:HW] : a_r[HW-1:0];
  assign b_part = cnt_r[1] ? b_r[OP_W-1:HW] : b_r[HW-1:0];

  // align the registered partial product
  always_comb begin
    case (sh_r)
      2'd1:    pp_sh = {{HW{1'b0}}, pp_r, {HW{1'b0}}};
      2'd2:    pp_sh = {pp_r, {OP_W{1'b0}}};
      default: pp_sh = {{OP_W{1'b0}}, pp_r};
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      pp_v_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        pp_v_r <= 1'b0;
        cnt_r  <= '0;
      end else if (run_r) begin
        if (cnt_r != 3'd4) begin
          pp_v_r <= 1'b1;
          cnt_r  <= cnt_r + 3'd1;
        end else begin
          pp_v_r <= 1'b0;
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands, partial products and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (run_r) begin
      if (pp_v_r) begin
        acc_r <= acc_r + pp_sh;
      end
      if (cnt_r != 3'd4) begin
        pp_r <= a_part * b_part;
        sh_r <= 2'(cnt_r[0]) + 2'(cnt_r[1]);
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/lsp_div.sv =====
// lsp_div.sv: restoring divider, one quotient bit per cycle, for the price ratio
`timescale 1ns / 1ps
module lsp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lsp_pkg::DVD_W-1:0] dividend,
  input  logic [lsp_pkg::VAL_W-1:0] divisor,
  output logic                      done,
  output logic [lsp_pkg::DVD_W-1:0] quotient
);
  import lsp_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic              run_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DVD_W-1:0]  q_r;
  logic [VAL_W-1:0]  rem_r;
  logic [VAL_W-1:0]  dvs_r;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    diff;
  logic              fits;

  // one restoring step
  assign trial = {rem_r, q_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      q_r   <= {q_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/lsp_dp.sv =====
// lsp_dp.sv: datapath with period stores, margin arithmetic, best search and result register
`timescale 1ns / 1ps
module lsp_dp #(
  parameter int MAX_PERIODS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lsp_pkg::lsp_cmd_t   cmd,
  output lsp_pkg::lsp_sts_t   sts,
  input  lsp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lsp_pkg::out_item_t  out_data
);
  import lsp_pkg::*;

  localparam int AW  = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
  localparam int BW  = $clog2(MAX_PERIODS + 1);
  localparam int HPW = VAL_W + AW;
  localparam int UW  = HPW + 1;

  // period stores
  logic [VAL_W-1:0]         suc_mem [MAX_PERIODS];
  logic [HPW-1:0]           hp_mem  [MAX_PERIODS];
  logic signed [COST_W-1:0] src_mem [MAX_PERIODS];
  logic signed [COST_W-1:0] bcs_mem [MAX_PERIODS+1];

  logic [VAL_W-1:0]         sucq_r;
  logic [HPW-1:0]           hpq_r;
  logic signed [COST_W-1:0] srcq_r;
  logic signed [COST_W-1:0] bcsq_r;

  // item and loop registers
  logic [AW:0]              pc_r;
  logic [AW-1:0]            t_r;
  logic [AW-1:0]            s_r;
  logic [VAL_W-1:0]         alpha_r, beta_r, prod_r, setup_r, hold_r;
  logic [HPW-1:0]           bt_r;
  logic [UW-1:0]            u_r;
  logic [DVD_W-1:0]         ratio_r;
  logic                     ratio_ok_r;
  logic [OP_W-1:0]          mmag_r, dmag_r;
  logic                     neg_r;
  logic signed [COST_W-1:0] best_r;
  logic [AW-1:0]            start_r;
  logic                     none_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  logic                     first_eff;
  logic [AW-1:0]            t_nxt;
  logic [VAL_W-1:0]         beta_nxt;
  logic                     div_done;
  logic [DVD_W-1:0]         quot;
  logic                     mul_done;
  logic [PROD_W-1:0]        mprod;
  logic [OP_W-1:0]          mul_a, mul_b;
  logic [AW-1:0]            hp_addr;
  logic [HPW-1:0]           hp_before_s;
  logic [UW-1:0]            u_nxt;
  logic signed [OP_W-1:0]   drop, diff, demand, margin;
  logic [COST_W-2:0]        tmag;
  logic                     tsat;
  logic signed [COST_W-1:0] term, src_new, cand;
  logic                     out_free;

  // new period index
  assign first_eff = in_data.first_period || (pc_r >= (AW+1)'(MAX_PERIODS));
  assign t_nxt     = first_eff ? '0 : pc_r[AW-1:0];
  assign beta_nxt  = (in_data.price_slope == '0) ? VAL_W'(1) : in_data.price_slope;

  // ratio divider, started on item load
  lsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .dividend ({in_data.demand_intercept, {(FRAC_BITS-1){1'b0}}}),
    .divisor  (beta_nxt),
    .done     (div_done),
    .quotient (quot)
  );

  // shared multiplier
  assign mul_a = cmd.mul2 ? mmag_r : OP_W'(u_r);
  assign mul_b = cmd.mul2 ? dmag_r : OP_W'(beta_r);

  lsp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul1 || cmd.mul2),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mprod)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      ratio_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ratio_ok_r <= 1'b0;
      end else if (div_done) begin
        ratio_ok_r <= 1'b1;
      end
      if (cmd.fin) begin
        pc_r <= {1'b0, t_r} + (AW+1)'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // holding prefix read address: t-1 once per item, s-1 per start
  assign hp_addr     = cmd.rd_bt ? (t_r - AW'(1)) : (s_r - AW'(1));
  assign hp_before_s = (s_r == '0) ? '0 : hpq_r;

  // store access
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      hp_mem[t_r]  <= ((t_r == '0) ? '0 : hpq_r) + HPW'(hold_r);
      suc_mem[t_r] <= prod_r;
      src_mem[t_r] <= $signed({{(COST_W-VAL_W){1'b0}}, setup_r});
      if (t_r == '0) begin
        bcs_mem[0] <= '0;
      end
    end
    if (cmd.upd) begin
      src_mem[s_r] <= src_new;
    end
    if (cmd.fin) begin
      bcs_mem[BW'(t_r) + BW'(1)] <= best_r;
    end
    if (cmd.rd_bt || cmd.rd) begin
      hpq_r <= hp_mem[hp_addr];
    end
    if (cmd.rd) begin
      sucq_r <= suc_mem[s_r];
      srcq_r <= src_mem[s_r];
      bcsq_r <= bcs_mem[BW'(s_r)];
    end
  end

  // margin, demand and term arithmetic
  assign u_nxt  = UW'(sucq_r) + UW'(bt_r) - UW'(hp_before_s);
  assign drop   = $signed(mprod[OP_W+FRAC_BITS-1:FRAC_BITS]);
  assign diff   = $signed(OP_W'(alpha_r)) - drop;
  assign demand = diff >>> 1;
  assign margin = $signed(OP_W'(u_r)) - $signed(OP_W'(ratio_r))
                  - $signed(OP_W'(u_r >> 1));
  assign tsat   = mprod[PROD_W-1:COST_W-1+FRAC_BITS] != '0;
  assign tmag   = mprod[COST_W-2+FRAC_BITS:FRAC_BITS];

  always_comb begin
    if (tsat) begin
      term = neg_r ? COST_MIN : COST_MAX;
    end else if (neg_r) begin
      term = -$signed({1'b0, tmag});
    end else begin
      term = $signed({1'b0, tmag});
    end
  end

  assign src_new = sat_add(srcq_r, term);
  assign cand    = sat_add(src_new, bcsq_r);

  // item, loop and search registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r     <= t_nxt;
      alpha_r <= in_data.demand_intercept;
      beta_r  <= beta_nxt;
      prod_r  <= in_data.unit_cost;
      setup_r <= in_data.setup_cost;
      hold_r  <= in_data.holding_cost;
    end
    if (div_done) begin
      ratio_r <= quot;
    end
    if (cmd.setup) begin
      bt_r    <= (t_r == '0) ? '0 : hpq_r;
      s_r     <= '0;
      best_r  <= '0;
      start_r <= '0;
      none_r  <= (t_r != '0);
    end
    if (cmd.calc_u) begin
      u_r <= u_nxt;
    end
    if (cmd.dem) begin
      neg_r  <= (margin < 0) != (demand < 0);
      mmag_r <= (margin < 0) ? OP_W'(-margin) : OP_W'(margin);
      dmag_r <= (demand < 0) ? OP_W'(-demand) : OP_W'(demand);
    end
    if (cmd.upd) begin
      if (t_r == '0) begin
        best_r <= cand;
      end else if (cand < best_r) begin
        best_r  <= cand;
        start_r <= s_r;
        none_r  <= 1'b0;
      end
      s_r <= s_r + AW'(1);
    end
    if (cmd.emit) begin
      out_r.best_cost     <= best_r;
      out_r.best_start    <= IDX_W'(start_r);
      out_r.no_production <= none_r;
      out_r.period_index  <= IDX_W'(t_r);
    end
  end

  // status
  assign out_free     = !out_valid_r || !out_stall;
  assign sts.ratio_ok = ratio_ok_r;
  assign sts.mul_done = mul_done;
  assign sts.last_s   = (s_r == t_r);
  assign sts.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/lsp_ctrl.sv =====
// lsp_ctrl.sv: sequencer that walks the start periods of one planning period
`timescale 1ns / 1ps
module lsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lsp_pkg::lsp_sts_t sts,
  output lsp_pkg::lsp_cmd_t cmd
);
  import lsp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDBT  = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_DIVW  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_U     = 4'd5;
  localparam logic [3:0] S_M1    = 4'd6;
  localparam logic [3:0] S_M1W   = 4'd7;
  localparam logic [3:0] S_DEM   = 4'd8;
  localparam logic [3:0] S_M2    = 4'd9;
  localparam logic [3:0] S_M2W   = 4'd10;
  localparam logic [3:0] S_UPD   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_RDBT;
        end
      end
      S_RDBT: begin
        cmd.rd_bt = 1'b1;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (sts.ratio_ok) state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_U;
      end
      S_U: begin
        cmd.calc_u = 1'b1;
        state_nxt  = S_M1;
      end
      S_M1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_M1W;
      end
      S_M1W: begin
        if (sts.mul_done) state_nxt = S_DEM;
      end
      S_DEM: begin
        cmd.dem   = 1'b1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_M2W;
      end
      S_M2W: begin
        if (sts.mul_done) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.last_s ? S_FIN : S_RD;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = !rst_n || (state_r != S_IDLE);

endmodule

// ===== rtl/lot_sizing_with_pricing_dp_core.sv =====
// lot_sizing_with_pricing_dp_core.sv: top level of the lot sizing with pricing recursion
// The ratio divider runs once per beat; each start period then makes two
// passes through the shared multiplier.
// One beat is in work at a time; the result register lets the next beat start.
// Synchronous active-low reset clears the sequencer, period count and valid flags.
`timescale 1ns / 1ps
module lot_sizing_with_pricing_dp_core #(
  parameter int MAX_PERIODS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lsp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lsp_pkg::out_item_t out_data
);
  import lsp_pkg::*;

  lsp_cmd_t cmd;
  lsp_sts_t sts;

  // sequencer
  lsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  lsp_dp #(
    .MAX_PERIODS (MAX_PERIODS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== verif/lot_sizing_with_pricing_dp_core_test.sv =====
// lot_sizing_with_pricing_dp_core_test.sv: self-checking testbench for the lot sizing dp core
`timescale 1ns / 1ps
module lot_sizing_with_pricing_dp_core_test;
  import lsp_pkg::*;

  localparam int         HORIZON     = 64;
  localparam int         HOLD_CYCLES = 1500;
  localparam int         STALL_LIMIT = 20000;
  localparam int         DRAIN_WAIT  = 1200;
  localparam longint     CMAX = 64'sd140737488355327;
  localparam longint     CMIN = -64'sd140737488355328;
  localparam longint unsigned CAP = 64'd1 << 60;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // model state of the recursion
  int              plan_period;
  longint unsigned plan_unit_cost [HORIZON];
  longint unsigned plan_hold_sum  [HORIZON];
  longint          plan_run_cost  [HORIZON];
  longint          plan_best      [HORIZON+1];

  out_item_t       plan_results[$];
  int              errors;
  int              beats_in;
  int              beats_out;
  int              idle_results;
  int              wraps;
  bit              no_idle;
  bit              hold_req;
  int              hold_cnt;
  int              quiet_cycles;

  lot_sizing_with_pricing_dp_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic longint clamp_cost(input longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // signed fixed-point product, truncated toward zero, clamped to cost range
  function automatic longint fix_mul(input longint a, input longint b);
    bit              neg;
    longint unsigned ua, ub, mag;
    logic [127:0]    p;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? longint'(-a) : a;
    ub  = (b < 0) ? longint'(-b) : b;
    p   = {64'd0, ua} * {64'd0, ub};
    mag = p[79:16];
    if (p[127:80] != 0 || mag >= (64'd1 << 47)) return neg ? CMIN : CMAX;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // (unit cost + holding - optimal price) times demand at that price
  function automatic longint price_margin(input longint unsigned u,
      input longint unsigned alpha, input longint unsigned beta);
    longint unsigned ratio, drop, price;
    longint          dem, mar;
    logic [127:0]    p;
    ratio = (alpha << 15) / beta;
    p     = {64'd0, u} * {64'd0, beta};
    drop  = p[79:16];
    if (p[127:80] != 0 || drop > CAP) drop = CAP;
    if (ratio > CAP) ratio = CAP;
    if (u > CAP) u = CAP;
    price = ratio + (u >> 1);
    dem   = (longint'(alpha) - longint'(drop)) >>> 1;
    mar   = longint'(u) - longint'(price);
    return fix_mul(mar, dem);
  endfunction

  // forward recursion step for one period
  function automatic out_item_t plan_period_step(input in_item_t it);
    longint unsigned beta, before_t, before_s, u;
    longint          best, cand;
    int              t, start;
    bit              none;
    out_item_t       r;
    beta = (it.price_slope == 0) ? 64'd1 : it.price_slope;
    if (it.first_period || plan_period >= HORIZON) begin
      if (!it.first_period && plan_period >= HORIZON) wraps++;
      plan_period = 0;
    end
    t = plan_period;
    if (t == 0) plan_best[0] = 0;
    before_t = t ? plan_hold_sum[t-1] : 0;
    plan_hold_sum[t]  = before_t + it.holding_cost;
    plan_unit_cost[t] = it.unit_cost;
    plan_run_cost[t]  = longint'(it.setup_cost);
    for (int s = 0; s <= t; s++) begin
      before_s = s ? plan_hold_sum[s-1] : 0;
      u = plan_unit_cost[s] + (before_t - before_s);
      plan_run_cost[s] = clamp_cost(plan_run_cost[s] +
                                    price_margin(u, it.demand_intercept, beta));
    end
    start = 0;
    none  = 1'b0;
    if (t == 0) begin
      best = plan_run_cost[0];
    end else begin
      best = 0;
      none = 1'b1;
      for (int s = 0; s <= t; s++) begin
        cand = clamp_cost(plan_run_cost[s] + plan_best[s]);
        if (cand < best) begin
          best  = cand;
          start = s;
          none  = 1'b0;
        end
      end
    end
    plan_best[t+1] = best;
    plan_period    = t + 1;
    r.best_cost     = best[47:0];
    r.best_start    = start[5:0];
    r.no_production = none;
    r.period_index  = t[5:0];
    return r;
  endfunction

  // one input beat, predicted on acceptance
  task automatic send_period(input in_item_t it);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    plan_results.push_back(plan_period_step(it));
    beats_in++;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 99) < 37) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  function automatic in_item_t random_period(input bit first);
    in_item_t it;
    it.first_period     = first;
    it.demand_intercept = pick_value();
    it.price_slope      = pick_value();
    if (it.price_slope == 0) it.price_slope = 32'd1;
    it.unit_cost        = pick_value();
    it.setup_cost       = pick_value();
    it.holding_cost     = pick_value();
    return it;
  endfunction

  task automatic wait_drained();
    while (plan_results.size() != 0) @(negedge clk);
  endtask

  // extremes, zero slope and the no-horizon-after-reset case
  task automatic test_directed();
    in_item_t it;
    it = '{1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'd0, 32'd0};
    send_period(it);
    it = '{1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0};
    send_period(it);
    it = '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
           32'hFFFF_FFFF};
    send_period(it);
    it = '{1'b1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0};
    send_period(it);
    it = '{1'b0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF};
    send_period(it);
    it = '{1'b0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0};
    send_period(it);
    it = '{1'b1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF};
    send_period(it);
    it = '{1'b0, 32'h0064_0000, 32'h0002_0000, 32'h0001_0000, 32'h0010_0000,
           32'h0000_4000};
    send_period(it);
    it = '{1'b0, 32'h0064_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_0000,
           32'h0000_4000};
    send_period(it);
    // profitable periods with cheap setups, then a dead one
    it = '{1'b1, 32'h0050_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
           32'h0000_1000};
    send_period(it);
    repeat (3) send_period(it);
    it = '{1'b0, 32'd0, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0};
    send_period(it);
    repeat (4) send_period(random_period(1'b0));
  endtask

  // run past the end of the horizon without a restart flag
  task automatic test_horizon_wrap();
    no_idle = 1'b1;
    send_period(random_period(1'b1));
    repeat (HORIZON + 1) send_period(random_period(1'b0));
    no_idle = 1'b0;
  endtask

  // receiver holds off while beats keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_period(random_period(1'b1));
    repeat (7) send_period(random_period(1'b0));
  endtask

  // sender pauses until every result is back
  task automatic test_drain_pause();
    in_valid = 1'b0;
    wait_drained();
    repeat (3) @(negedge clk);
    repeat (4) send_period(random_period(1'b0));
  endtask

  // mostly short horizons with random content
  task automatic test_random(input int count);
    int left;
    left = 0;
    for (int n = 0; n < count; n++) begin
      no_idle = (n >= 200 && n < 300);
      if (left == 0) begin
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70)
                                           : $urandom_range(1, 8);
        send_period(random_period($urandom_range(0, 15) != 0));
      end else begin
        send_period(random_period(1'b0));
      end
      left--;
    end
    no_idle = 1'b0;
  endtask

  // receiver stall, with a counted long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_cnt  = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 37);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (plan_results.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, out_data);
        errors++;
      end else begin
        want = plan_results.pop_front();
        if (out_data.no_production) idle_results++;
        if (out_data.best_cost !== want.best_cost) begin
          $display("%0t: best_cost expected %0d got %0d", $time,
                   want.best_cost, out_data.best_cost);
          errors++;
        end
        if (out_data.best_start !== want.best_start) begin
          $display("%0t: best_start expected %0d got %0d", $time,
                   want.best_start, out_data.best_start);
          errors++;
        end
        if (out_data.no_production !== want.no_production) begin
          $display("%0t: no_production expected %0d got %0d", $time,
                   want.no_production, out_data.no_production);
          errors++;
        end
        if (out_data.period_index !== want.period_index) begin
          $display("%0t: period_index expected %0d got %0d", $time,
                   want.period_index, out_data.period_index);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", quiet_cycles);
      $display("lot_sizing_with_pricing_dp_core_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    hold_cnt     = 0;
    quiet_cycles = 0;
    errors       = 0;
    beats_in     = 0;
    beats_out    = 0;
    idle_results = 0;
    wraps        = 0;
    plan_period  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_horizon_wrap();
    test_backpressure();
    test_drain_pause();
    test_random(640);

    in_valid = 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("covered %0d periods in, %0d results out, %0d horizon wraps,",
             beats_in, beats_out, wraps);
    $display("%0d results with no production, %0d mismatches", idle_results, errors);
    if (errors == 0) begin
      $display("lot_sizing_with_pricing_dp_core_test OK");
    end else begin
      $display("lot_sizing_with_pricing_dp_core_test NOT OK");
    end
    $finish;
  end

endmodule
